### src/tjlik_pkg.sv
// ----------------------------------------------------------------------------
// Leg inverse kinematics package
// Shared widths, register indexes, CORDIC angle table and pipeline word types.
// ----------------------------------------------------------------------------
package tjlik_pkg;

   localparam int CORDIC_STEPS = 16;

   localparam logic [2:0] REG_COXA    = 3'd0;
   localparam logic [2:0] REG_FEMUR   = 3'd1;
   localparam logic [2:0] REG_TIBIA   = 3'd2;
   localparam logic [2:0] REG_HIP_OFS = 3'd3;
   localparam logic [2:0] REG_FEM_OFS = 3'd4;
   localparam logic [2:0] REG_KNE_OFS = 3'd5;

   // CORDIC operands, wide enough for the acos stage (Q30) and coordinates << 16
   localparam int CW = 48;
   // angle in degrees, 16 fraction bits
   localparam int AW = 28;

   localparam logic signed [AW-1:0] DEG90  = AW'(90 * 65536);
   localparam logic signed [AW-1:0] DEG180 = AW'(180 * 65536);

   function automatic logic signed [AW-1:0] atan_entry(input logic [3:0] i);
      logic signed [AW-1:0] v;
      case (i)
         4'd0: v = AW'(2949120);
         4'd1: v = AW'(1740967);
         4'd2: v = AW'(919879);
         4'd3: v = AW'(466945);
         4'd4: v = AW'(234379);
         4'd5: v = AW'(117304);
         4'd6: v = AW'(58666);
         4'd7: v = AW'(29335);
         4'd8: v = AW'(14668);
         4'd9: v = AW'(7334);
         4'd10: v = AW'(3667);
         4'd11: v = AW'(1833);
         4'd12: v = AW'(917);
         4'd13: v = AW'(458);
         4'd14: v = AW'(229);
         default: v = AW'(115);
      endcase
      return v;
   endfunction

   // one word moving through a CORDIC cell row
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] ang;
      logic                 fixed;   // result settled by a special case
   } cordic_type;

endpackage

### src/three_joint_leg_inverse_kinematics.sv
// A foot target accepted at a clock edge is strobed out after the knee chain in series:
// square root, distance, cosine terms, divider, q squared, square root, CORDIC and
// output scaling.
// Throughput one word per cycle; the receiver cannot stall, so busy stays 0.
// Synchronous reset clears the strobe pipeline and loads the register defaults.
// ----------------------------------------------------------------------------
// Three-joint leg inverse kinematics
// Hip, femur and knee servo angles from a foot target, built of cell rows.
// ----------------------------------------------------------------------------
module three_joint_leg_inverse_kinematics
   import tjlik_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_foot_x,
   input  logic signed [15:0] req_foot_y,
   input  logic signed [15:0] req_foot_z,
   input  logic [2:0]         req_leg,
   output logic               rsp_valid,
   output logic [2:0]         rsp_leg_out,
   output logic signed [9:0]  rsp_hip_angle,
   output logic signed [9:0]  rsp_femur_angle,
   output logic signed [9:0]  rsp_knee_angle,
   output logic               rsp_out_of_reach,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [12:0]        csr_data
);

   // stage timing
   localparam int TS1 = 32;             // r root
   localparam int TD  = TS1 + 1;        // d ready
   localparam int TC  = TD + 2;         // c2, num, den ready
   localparam int TQ  = TC + 1 + 31;    // q registered
   localparam int TQQ = TQ + 1;         // q*q registered
   localparam int TS2 = TQQ + 32;       // s root
   localparam int TG  = TS2 + 16;       // acos angle
   localparam int LAT = TG + 1;
   localparam int TB  = TD + 16;        // beta angle
   localparam int TA  = 16;             // alpha angle

   logic [12:0] coxa_ff, femur_ff, tibia_ff;
   logic signed [8:0] hofs_ff, fofs_ff, kofs_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         coxa_ff  <= 13'd896;
         femur_ff <= 13'd1065;
         tibia_ff <= 13'd2099;
         hofs_ff  <= 9'sd142;
         fofs_ff  <= -9'sd6;
         kofs_ff  <= -9'sd3;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_COXA:    coxa_ff  <= csr_data;
            REG_FEMUR:   femur_ff <= csr_data;
            REG_TIBIA:   tibia_ff <= csr_data;
            REG_HIP_OFS: hofs_ff  <= csr_data[8:0];
            REG_FEM_OFS: fofs_ff  <= csr_data[8:0];
            REG_KNE_OFS: kofs_ff  <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   logic acc;
   assign acc = start;

   // delay lines for control and pass-through fields
   logic        vld_ff [LAT+1];
   logic [2:0]  leg_ff [LAT];
   logic        neg_ff [TS1];
   logic signed [15:0] y_ff [TD];
   logic signed [AW-1:0] al_ff [LAT-TA-1];
   logic signed [AW-1:0] be_ff [LAT-TB];
   logic        flg_ff [LAT-TQ+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAT; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= acc;
         for (int i = 1; i <= LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
      leg_ff[0] <= req_leg;
      for (int i = 1; i < LAT; i++) leg_ff[i] <= leg_ff[i-1];
      neg_ff[0] <= req_foot_x[15];
      for (int i = 1; i < TS1; i++) neg_ff[i] <= neg_ff[i-1];
      y_ff[0] <= req_foot_y;
      for (int i = 1; i < TD; i++) y_ff[i] <= y_ff[i-1];
   end

   // alpha
   logic signed [CW-1:0] ax, az;
   logic signed [AW-1:0] alpha;
   always_comb begin
      ax = CW'(req_foot_x) <<< 16;
      az = CW'(req_foot_z) <<< 16;
      if (req_foot_x[15]) begin
         ax = -ax;
         az = -az;
      end
   end
   tjlik_cordic_row u_alpha (.clock(clock), .x(ax), .y(az), .ang(alpha));

   // r = sqrt((x^2+z^2) << 16)
   logic [31:0] xsq, zsq;
   logic [63:0] rad;
   logic [31:0] rroot;
   always_comb begin
      xsq = 32'(req_foot_x * req_foot_x);
      zsq = 32'(req_foot_z * req_foot_z);
      rad = {15'd0, ({1'b0, xsq} + {1'b0, zsq}), 16'd0};
   end
   tjlik_sqrt_row u_rsqrt (.clock(clock), .value(rad), .root(rroot));

   // d = |r - coxa<<8| with r negated for a negative x, registered at TD
   logic signed [26:0] d_ff;
   logic signed [26:0] r_s, d_t;
   always_comb begin
      r_s = neg_ff[TS1-1] ? -27'(rroot) : 27'(rroot);
      d_t = r_s - 27'({coxa_ff, 8'd0});
      if (d_t < 0) d_t = -d_t;
   end
   always_ff @(posedge clock) d_ff <= d_t;

   // beta
   logic signed [AW-1:0] bang;
   tjlik_cordic_row u_beta (
      .clock(clock),
      .x(CW'(d_ff) <<< 8),
      .y(CW'(y_ff[TD-1]) <<< 16),
      .ang(bang));

   // c2, num, den
   logic [51:0] dsq_ff;
   logic [31:0] ysq_ff;
   logic [26:0] ab2_ff;
   logic [26:0] a2b2_ff;
   always_ff @(posedge clock) begin
      dsq_ff  <= 52'(d_ff) * 52'(d_ff);
      ysq_ff  <= 32'(y_ff[TD-1] * y_ff[TD-1]);
      ab2_ff  <= {26'(femur_ff * tibia_ff), 1'b0};
      a2b2_ff <= 27'(femur_ff * femur_ff) + 27'(tibia_ff * tibia_ff);
   end
   logic signed [37:0] num_ff;
   logic [26:0] den_ff;
   always_ff @(posedge clock) begin
      num_ff <= 38'(a2b2_ff) - 38'(dsq_ff[51:16]) - 38'(ysq_ff);
      den_ff <= ab2_ff;
   end

   // clamp and flag, then divide |num|
   logic [27:0] dn_num;
   logic        qneg_ff [1:TQ-TC-1];
   logic        qsat_ff [1:TQ-TC-1];
   logic        qneg_c, qsat_c;
   logic [37:0] anum;
   always_comb begin
      anum   = num_ff[37] ? -num_ff : num_ff;
      qsat_c = (den_ff == '0) || (anum > 38'(den_ff));
      dn_num = qsat_c ? 28'(den_ff) : anum[27:0];
      qneg_c = num_ff[37];
   end
   always_ff @(posedge clock) begin
      qneg_ff[1] <= qneg_c;
      qsat_ff[1] <= qsat_c;
      for (int i = 2; i < TQ-TC; i++) begin
         qneg_ff[i] <= qneg_ff[i-1];
         qsat_ff[i] <= qsat_ff[i-1];
      end
   end
   logic [30:0] quot;
   tjlik_div_row u_div (.clock(clock), .num(dn_num), .den({1'b0, den_ff}), .quot(quot));

   logic signed [31:0] q_ff;
   logic [30:0] qm;
   always_comb qm = qsat_ff[TQ-TC-1] ? 31'h4000_0000 : quot;
   always_ff @(posedge clock) begin
      q_ff <= qneg_ff[TQ-TC-1] ? -32'(qm) : 32'(qm);
      flg_ff[0] <= qsat_ff[TQ-TC-1];
      for (int i = 1; i <= LAT-TQ; i++) flg_ff[i] <= flg_ff[i-1];
   end

   // s = sqrt(2^60 - q^2)
   logic [61:0] qsq_ff;
   logic signed [31:0] qd_ff [33];
   always_ff @(posedge clock) begin
      qsq_ff <= 62'(q_ff * q_ff);
      qd_ff[0] <= q_ff;
      for (int i = 1; i < 33; i++) qd_ff[i] <= qd_ff[i-1];
   end
   logic [31:0] sroot;
   tjlik_sqrt_row u_ssqrt (
      .clock(clock), .value(64'h1000_0000_0000_0000 - 64'(qsq_ff)), .root(sroot));

   logic signed [AW-1:0] gang;
   logic signed [31:0] qa;
   logic               qn_ff [16];
   always_comb qa = qd_ff[32][31] ? -qd_ff[32] : qd_ff[32];
   tjlik_cordic_row u_acos (
      .clock(clock), .x(CW'(qa)), .y(CW'(sroot)), .ang(gang));
   always_ff @(posedge clock) begin
      qn_ff[0] <= qd_ff[32][31];
      for (int i = 1; i < 16; i++) qn_ff[i] <= qn_ff[i-1];
   end

   // align alpha and beta to the end
   always_ff @(posedge clock) begin
      al_ff[0] <= alpha;
      for (int i = 1; i <= LAT-TA-2; i++) al_ff[i] <= al_ff[i-1];
      be_ff[0] <= bang + DEG90;
      for (int i = 1; i < LAT-TB; i++) be_ff[i] <= be_ff[i-1];
   end

   // final scaling: stage 1 multiply, stage 2 truncate
   logic signed [AW-1:0] acs, gam_ff;
   logic signed [47:0] hp_ff;
   always_comb acs = qn_ff[15] ? (DEG180 - gang) : gang;
   always_ff @(posedge clock) begin
      gam_ff <= DEG180 - acs + (AW'(kofs_ff) <<< 16);
      hp_ff  <= (48'(hofs_ff) <<< 32) - 48'(al_ff[LAT-TA-2]) * 48'sd54591;
   end

   function automatic logic signed [9:0] trz(input logic signed [47:0] v,
                                             input logic [5:0] sh);
      logic signed [47:0] a;
      a = v[47] ? -v : v;
      a = a >>> sh;
      return v[47] ? -10'(a) : 10'(a);
   endfunction

   logic signed [47:0] fem_v;
   always_comb fem_v = 48'(be_ff[LAT-TB-1]) + (48'(fofs_ff) <<< 16);

   always_ff @(posedge clock) begin
      rsp_hip_angle    <= trz(hp_ff, 6'd32);
      rsp_femur_angle  <= trz(fem_v, 6'd16);
      rsp_knee_angle   <= trz(48'(gam_ff), 6'd16);
      rsp_out_of_reach <= flg_ff[LAT-TQ];
      rsp_leg_out      <= leg_ff[LAT-1];
   end

   assign rsp_valid = vld_ff[LAT];

endmodule

### src/tjlik_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One registered rotation step; shifts truncate toward zero.
// ----------------------------------------------------------------------------
module tjlik_cordic_cell
   import tjlik_pkg::*;
(
   input  logic       clock,
   input  logic [3:0] step,
   input  cordic_type cin,
   output cordic_type cout
);

   cordic_type out_ff, out_in;
   logic signed [CW-1:0] xs, ys;

   always_comb begin
      xs = cin.x[CW-1] ? -((-cin.x) >>> step) : (cin.x >>> step);
      ys = cin.y[CW-1] ? -((-cin.y) >>> step) : (cin.y >>> step);
      out_in = cin;
      if (!cin.fixed) begin
         if (cin.y > 0) begin
            out_in.x   = cin.x + ys;
            out_in.y   = cin.y - xs;
            out_in.ang = cin.ang + atan_entry(step);
         end else begin
            out_in.x   = cin.x - ys;
            out_in.y   = cin.y + xs;
            out_in.ang = cin.ang - atan_entry(step);
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign cout = out_ff;

endmodule

### src/tjlik_cordic_row.sv
// ----------------------------------------------------------------------------
// CORDIC atan row
// Sixteen chained cells; atan(y/x) in degrees Q16 for x >= 0, with zero cases.
// ----------------------------------------------------------------------------
module tjlik_cordic_row
   import tjlik_pkg::*;
(
   input  logic                 clock,
   input  logic signed [CW-1:0] x,
   input  logic signed [CW-1:0] y,
   output logic signed [AW-1:0] ang
);

   cordic_type link [CORDIC_STEPS+1];

   always_comb begin
      link[0].x     = x;
      link[0].y     = y;
      link[0].fixed = (y == '0) || (x == '0);
      if (y == '0)
         link[0].ang = '0;
      else if (x == '0)
         link[0].ang = (y > 0) ? DEG90 : -DEG90;
      else
         link[0].ang = '0;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      tjlik_cordic_cell u_cell (
         .clock(clock),
         .step (4'(i)),
         .cin  (link[i]),
         .cout (link[i+1])
      );
   end

   assign ang = link[CORDIC_STEPS].ang;

endmodule

### src/tjlik_sqrt_row.sv
// ----------------------------------------------------------------------------
// Integer square root row
// Restoring floor root of a 64-bit word, two radicand bits per cell, 32 cells.
// ----------------------------------------------------------------------------
module tjlik_sqrt_row (
   input  logic        clock,
   input  logic [63:0] value,
   output logic [31:0] root
);

   logic [63:0] rad_ff [33];
   logic [33:0] rem_ff [33];
   logic [31:0] rt_ff  [33];

   always_comb begin
      rad_ff[0] = value;
      rem_ff[0] = '0;
      rt_ff[0]  = '0;
   end

   for (genvar i = 0; i < 32; i++) begin : g_cell
      logic [33:0] rem_in, trial;
      logic [31:0] rt_in;
      always_comb begin
         rem_in = {rem_ff[i][31:0], rad_ff[i][63:62]};
         trial  = {rt_ff[i], 2'b01};
         rt_in  = {rt_ff[i][30:0], 1'b0};
         if (rem_in >= trial) begin
            rem_in = rem_in - trial;
            rt_in  = {rt_ff[i][30:0], 1'b1};
         end
      end
      always_ff @(posedge clock) begin
         rad_ff[i+1] <= {rad_ff[i][61:0], 2'b00};
         rem_ff[i+1] <= rem_in;
         rt_ff[i+1]  <= rt_in;
      end
   end

   assign root = rt_ff[32];

endmodule

### src/tjlik_div_row.sv
// ----------------------------------------------------------------------------
// Restoring divider row
// Unsigned 31-bit quotient of num*2^30/den for num <= den, one bit per cell.
// ----------------------------------------------------------------------------
module tjlik_div_row (
   input  logic        clock,
   input  logic [27:0] num,
   input  logic [27:0] den,
   output logic [30:0] quot
);

   logic [28:0] rem_ff [32];
   logic [27:0] den_ff [32];
   logic [30:0] q_ff   [32];

   always_comb begin
      rem_ff[0] = {1'b0, num};
      den_ff[0] = den;
      q_ff[0]   = '0;
   end

   // first cell produces bit 30 from num itself, later cells shift
   for (genvar i = 0; i < 31; i++) begin : g_cell
      logic [28:0] r;
      logic        b;
      always_comb begin
         r = (i == 0) ? rem_ff[i] : {rem_ff[i][27:0], 1'b0};
         b = (r >= {1'b0, den_ff[i]});
         if (b)
            r = r - {1'b0, den_ff[i]};
      end
      always_ff @(posedge clock) begin
         rem_ff[i+1] <= r;
         den_ff[i+1] <= den_ff[i];
         q_ff[i+1]   <= {q_ff[i][29:0], b};
      end
   end

   assign quot = q_ff[31];

endmodule
